>>> rtl/sycon_permutation_320_macros.svh
// Assertion macros for the Sycon 320-bit permutation checker.
// Used by the port checker; depends on clk and arst_n in the including scope.
`ifndef SYCON_PERMUTATION_320_MACROS_SVH
`define SYCON_PERMUTATION_320_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define SYCON_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define SYCON_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/sycon_pkg.sv
// Shared types, constants and round functions of the Sycon 320-bit permutation.
// No dependencies; imported by the round logic, the top level and the checker.
package sycon_pkg;

	localparam int WORD_W     = 64;
	localparam int NUM_WORDS  = 5;
	localparam int NUM_ROUNDS = 12;
	localparam int ROUND_W    = $clog2(NUM_ROUNDS);
	localparam int OCC_W      = $clog2(NUM_ROUNDS + 1);

	// Lower seven bytes of the round constant added to word two.
	localparam logic [WORD_W-9:0] RC_LOW = 56'haaaaaaaaaaaaaa;

	typedef logic [WORD_W-1:0] word_t;
	typedef word_t [NUM_WORDS-1:0] state_t;

	// Left rotation of one state word by a fixed amount.
	function automatic word_t rol(input word_t x, input int unsigned r);
		word_t res;
		res = (r % WORD_W == 0) ? x : ((x << (r % WORD_W)) | (x >> (WORD_W - r % WORD_W)));
		return res;
	endfunction

	// Word diffusion: rotate the XOR of the word and two of its rotations.
	function automatic word_t mix(input word_t x, input int unsigned a, input int unsigned b,
			input int unsigned c);
		word_t res;
		res = rol(x ^ rol(x, a) ^ rol(x, b), c);
		return res;
	endfunction

	// Top byte of the round constant for each round.
	function automatic logic [7:0] rc_byte(input logic [ROUND_W-1:0] idx);
		logic [7:0] res;
		case (idx)
			4'd0:    res = 8'h05;
			4'd1:    res = 8'h0a;
			4'd2:    res = 8'h0d;
			4'd3:    res = 8'h0e;
			4'd4:    res = 8'h0f;
			4'd5:    res = 8'h07;
			4'd6:    res = 8'h03;
			4'd7:    res = 8'h01;
			4'd8:    res = 8'h08;
			4'd9:    res = 8'h04;
			4'd10:   res = 8'h02;
			4'd11:   res = 8'h09;
			default: res = 8'h00;
		endcase
		return res;
	endfunction

endpackage

>>> rtl/sycon_round.sv
// One Sycon round: S-box layer, word diffusion and round constant addition.
// Depends on sycon_pkg for the state type and the rotation helpers.
module sycon_round (
	input  sycon_pkg::state_t   state_in,
	input  logic [7:0]          rc,
	output sycon_pkg::state_t   state_out
);
	import sycon_pkg::*;

	word_t a, b, c, d;
	word_t n0, n1, n2, n3, n4;

	// S-box layer applied across the five-bit slices of the words.
	always_comb begin
		a  = state_in[2] ^ state_in[4];
		b  = a ^ state_in[1];
		c  = state_in[1] ^ state_in[3];
		d  = state_in[0] ^ state_in[4];
		n0 = d ^ (b & state_in[3]);
		n1 = (~state_in[1] & state_in[3]) ^ b ^ (~c & state_in[0]);
		n2 = (~d & state_in[2]) ^ c;
		n3 = (~a & state_in[3]) ^ state_in[0] ^ ~state_in[2];
		n4 = (~state_in[4] & state_in[0]) ^ c;
	end

	// Diffusion layer, with the round constant folded into word two.
	always_comb begin
		state_out[0] = mix(n0, 59, 54, 40);
		state_out[1] = mix(n1, 55, 46, 32);
		state_out[2] = mix(n2, 33, 2, 16) ^ {rc, RC_LOW};
		state_out[3] = mix(n3, 21, 42, 56);
		state_out[4] = n4 ^ rol(n4, 13) ^ rol(n4, 26);
	end

endmodule

>>> rtl/sycon_permutation_320.sv
// Sycon 320-bit permutation, 12 rounds, one pipeline stage per round.
// Depends on sycon_pkg and sycon_round.
//
// Usage: the input channel (in_valid, in_stall, in_word0..in_word4) carries one
// 320-bit state per transfer, word 0 holding bytes 0-7 big-endian. The output
// channel (out_valid, out_stall, out_word0..out_word4) returns the permuted
// state in the same order, one result per input, in input order.
// Each round has its own register stage, and the last stage drives the output
// ports. Throughput is one state per cycle while out_stall is low; a new state
// may enter in every cycle in which in_stall is low.
// When the receiver stalls, the last stage holds its result and earlier
// stages keep moving until they close up behind it; in_stall rises only when
// the first stage is occupied and cannot move on.
// Reset clears all stage valid bits, so out_valid is low after reset and the
// block accepts a state in the first cycle.
module sycon_permutation_320 (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  sycon_pkg::word_t    in_word0,
	input  sycon_pkg::word_t    in_word1,
	input  sycon_pkg::word_t    in_word2,
	input  sycon_pkg::word_t    in_word3,
	input  sycon_pkg::word_t    in_word4,
	output logic                out_valid,
	input  logic                out_stall,
	output sycon_pkg::word_t    out_word0,
	output sycon_pkg::word_t    out_word1,
	output sycon_pkg::word_t    out_word2,
	output sycon_pkg::word_t    out_word3,
	output sycon_pkg::word_t    out_word4
);
	import sycon_pkg::*;

	state_t pipe_state_s [NUM_ROUNDS];
	logic   pipe_vld_s   [NUM_ROUNDS];
	state_t round_in     [NUM_ROUNDS];
	state_t round_out    [NUM_ROUNDS];
	logic   stage_rdy    [NUM_ROUNDS+1];
	logic   src_vld      [NUM_ROUNDS];

	// A stage may load when it is empty or its content moves on this cycle.
	assign stage_rdy[NUM_ROUNDS] = !out_stall;

	genvar k;
	generate
		for (k = 0; k < NUM_ROUNDS; k++) begin : g_stage
			assign stage_rdy[k] = !pipe_vld_s[k] || stage_rdy[k+1];

			if (k == 0) begin : g_first
				assign round_in[k] = {in_word4, in_word3, in_word2, in_word1, in_word0};
				assign src_vld[k]  = in_valid;
			end else begin : g_next
				assign round_in[k] = pipe_state_s[k-1];
				assign src_vld[k]  = pipe_vld_s[k-1];
			end

			sycon_round u_round (
				.state_in  (round_in[k]),
				.rc        (rc_byte(ROUND_W'(k))),
				.state_out (round_out[k])
			);

			// Valid bit of the stage.
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					pipe_vld_s[k] <= 1'b0;
				end else if (stage_rdy[k]) begin
					pipe_vld_s[k] <= src_vld[k];
				end
			end

			// Stage data loads only with a valid transfer from the stage before.
			always_ff @(posedge clk) begin
				if (stage_rdy[k] && src_vld[k]) begin
					pipe_state_s[k] <= round_out[k];
				end
			end
		end
	endgenerate

	// Port side of the pipeline.
	assign in_stall  = !stage_rdy[0];
	assign out_valid = pipe_vld_s[NUM_ROUNDS-1];
	assign out_word0 = pipe_state_s[NUM_ROUNDS-1][0];
	assign out_word1 = pipe_state_s[NUM_ROUNDS-1][1];
	assign out_word2 = pipe_state_s[NUM_ROUNDS-1][2];
	assign out_word3 = pipe_state_s[NUM_ROUNDS-1][3];
	assign out_word4 = pipe_state_s[NUM_ROUNDS-1][4];

endmodule

>>> rtl/sycon_checker.sv
// Port-level checker for the Sycon 320-bit permutation, bound to the top level.
// Depends on sycon_pkg and sycon_permutation_320_macros.svh.
`include "sycon_permutation_320_macros.svh"

module sycon_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic                out_valid,
	input  logic                out_stall,
	input  sycon_pkg::word_t    out_word0,
	input  sycon_pkg::word_t    out_word1,
	input  sycon_pkg::word_t    out_word2,
	input  sycon_pkg::word_t    out_word3,
	input  sycon_pkg::word_t    out_word4
);
	import sycon_pkg::*;

	logic             in_xfer;
	logic             out_xfer;
	logic [OCC_W-1:0] occ_q;

	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid && !out_stall;

	// Number of states accepted whose results have not yet been transferred.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			occ_q <= occ_q + OCC_W'(in_xfer) - OCC_W'(out_xfer);
		end
	end

	`SYCON_ASSERT_IMP(a_occ_bound, 1'b1, occ_q <= OCC_W'(NUM_ROUNDS), "more states in flight than stages")
	`SYCON_ASSERT_IMP(a_out_has_src, out_valid, occ_q != '0, "result shown with no state in flight")
	`SYCON_ASSERT_NEXT(a_empty_no_out, occ_q == '0 && !in_xfer, !out_valid, "result appeared from an empty pipeline")
	`SYCON_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "stalled result withdrawn")
	`SYCON_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_word0) && $stable(out_word1) && $stable(out_word2) && $stable(out_word3) && $stable(out_word4), "stalled result changed")

endmodule

bind sycon_permutation_320 sycon_checker u_sycon_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_word0 (out_word0),
	.out_word1 (out_word1),
	.out_word2 (out_word2),
	.out_word3 (out_word3),
	.out_word4 (out_word4)
);

>>> sim/sycon_permutation_320_checker.sv
// Checker for the Sycon 320-bit permutation: watches both channels, predicts every
// permuted state and compares it word by word with what the block returns.
// Depends on sycon_pkg for the word and state types and the round count.
module sycon_permutation_320_checker
	import sycon_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  logic  in_stall,
	input  word_t in_word0,
	input  word_t in_word1,
	input  word_t in_word2,
	input  word_t in_word3,
	input  word_t in_word4,
	input  logic  out_valid,
	input  logic  out_stall,
	input  word_t out_word0,
	input  word_t out_word1,
	input  word_t out_word2,
	input  word_t out_word3,
	input  word_t out_word4,
	output int    mismatches,
	output int    results_seen,
	output int    states_in_flight
);
	timeunit 1ns;
	timeprecision 1ps;

	// Top byte of the constant added to word two in each round.
	localparam logic [7:0] RC_TOP [0:NUM_ROUNDS-1] = '{
		8'h05, 8'h0a, 8'h0d, 8'h0e, 8'h0f, 8'h07,
		8'h03, 8'h01, 8'h08, 8'h04, 8'h02, 8'h09
	};

	state_t expected_states[$];
	int     n_mismatch = 0;
	int     n_results  = 0;

	assign mismatches       = n_mismatch;
	assign results_seen     = n_results;
	assign states_in_flight = expected_states.size();

	// Left rotation taken as a window out of the word written twice.
	function automatic word_t rotl(input word_t x, input int unsigned r);
		logic [2*WORD_W-1:0] dbl;
		dbl = {x, x};
		return dbl[2*WORD_W-1-r -: WORD_W];
	endfunction

	function automatic word_t spread(input word_t x, input int unsigned a,
			input int unsigned b, input int unsigned c);
		return rotl(x ^ rotl(x, a) ^ rotl(x, b), c);
	endfunction

	// Full permutation: S-box on bit slices, word diffusion, round constant.
	function automatic state_t sycon_permute(input state_t s);
		word_t  x0, x1, x2, x3, x4;
		word_t  a, b, c, d;
		word_t  n0, n1, n2, n3, n4;
		state_t r;
		x0 = s[0];
		x1 = s[1];
		x2 = s[2];
		x3 = s[3];
		x4 = s[4];
		for (int rnd = 0; rnd < NUM_ROUNDS; rnd++) begin
			a  = x2 ^ x4;
			b  = a ^ x1;
			c  = x1 ^ x3;
			d  = x0 ^ x4;
			n0 = d ^ (b & x3);
			n1 = (~x1 & x3) ^ b ^ (~c & x0);
			n2 = (~d & x2) ^ c;
			n3 = (~a & x3) ^ x0 ^ ~x2;
			n4 = (~x4 & x0) ^ c;
			x0 = spread(n0, 59, 54, 40);
			x1 = spread(n1, 55, 46, 32);
			x2 = spread(n2, 33, 2, 16);
			x3 = spread(n3, 21, 42, 56);
			x4 = n4 ^ rotl(n4, 13) ^ rotl(n4, 26);
			x2 ^= {RC_TOP[rnd], {7{8'haa}}};
		end
		r[0] = x0;
		r[1] = x1;
		r[2] = x2;
		r[3] = x3;
		r[4] = x4;
		return r;
	endfunction

	// Inputs change only at the rising edge, so the levels seen at the falling
	// edge decide which transfers happen at the next rising edge.
	always @(negedge clk) begin : watch_channels
		state_t got;
		state_t want;
		state_t taken;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got = {out_word4, out_word3, out_word2, out_word1, out_word0};
				if (expected_states.size() == 0) begin
					$error("out transfer with no state in flight: %h", got);
					n_mismatch++;
				end else begin
					want = expected_states.pop_front();
					n_results++;
					for (int w = 0; w < NUM_WORDS; w++) begin
						if (got[w] !== want[w]) begin
							$error("out_word%0d: expected %h, actual %h", w, want[w], got[w]);
							n_mismatch++;
						end
					end
				end
			end
			if (in_valid && !in_stall) begin
				taken = {in_word4, in_word3, in_word2, in_word1, in_word0};
				expected_states.push_back(sycon_permute(taken));
			end
		end
	end

endmodule

>>> sim/tb_sycon_permutation_320.sv
// Top of the Sycon 320-bit permutation testbench: clock, reset, input states and
// output back-pressure, plus the final verdict.
// Depends on sycon_pkg, sycon_permutation_320 and sycon_permutation_320_checker.
module tb_sycon_permutation_320;
	timeunit 1ns;
	timeprecision 1ps;
	import sycon_pkg::*;

	localparam int CLK_HALF     = 4;
	localparam int RESET_CYCLES = 7;
	localparam int RANDOM_ITEMS = 1800;
	localparam int HOLD_AT      = 400;
	localparam int HOLD_CYCLES  = 80;
	localparam int CALM_FROM    = 1600;
	localparam int DRAIN_CYCLES = 30;
	localparam int LIMIT_CYCLES = 400000;

	logic  clk = 1'b0;
	logic  arst_n;
	logic  in_valid;
	logic  in_stall;
	word_t in_word0, in_word1, in_word2, in_word3, in_word4;
	logic  out_valid;
	logic  out_stall;
	word_t out_word0, out_word1, out_word2, out_word3, out_word4;

	int mismatches;
	int results_seen;
	int states_in_flight;
	int n_sent = 0;
	int n_directed = 0;
	bit hold_request = 1'b0;

	always #(CLK_HALF) clk = ~clk;

	sycon_permutation_320 DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word0  (in_word0),
		.in_word1  (in_word1),
		.in_word2  (in_word2),
		.in_word3  (in_word3),
		.in_word4  (in_word4),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word0 (out_word0),
		.out_word1 (out_word1),
		.out_word2 (out_word2),
		.out_word3 (out_word3),
		.out_word4 (out_word4)
	);

	sycon_permutation_320_checker u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.in_word0         (in_word0),
		.in_word1         (in_word1),
		.in_word2         (in_word2),
		.in_word3         (in_word3),
		.in_word4         (in_word4),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.out_word0        (out_word0),
		.out_word1        (out_word1),
		.out_word2        (out_word2),
		.out_word3        (out_word3),
		.out_word4        (out_word4),
		.mismatches       (mismatches),
		.results_seen     (results_seen),
		.states_in_flight (states_in_flight)
	);

	// Idling is allowed in most stretches, never in some, and never near the end.
	function automatic bit idle_allowed();
		return (n_sent < CALM_FROM) && ((n_sent % 300) < 240);
	endfunction

	// Offer one state and hold it until the transfer happens.
	task automatic offer_state(input state_t s);
		bit taken;
		in_valid <= 1'b1;
		in_word0 <= s[0];
		in_word1 <= s[1];
		in_word2 <= s[2];
		in_word3 <= s[3];
		in_word4 <= s[4];
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
		n_sent++;
		if (n_sent == HOLD_AT)
			hold_request = 1'b1;
		// Random gap on the input side.
		if (idle_allowed() && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	endtask

	// Random word, now and then a single set or single cleared bit.
	function automatic word_t random_word();
		word_t w;
		w = {$urandom, $urandom};
		case ($urandom_range(0, 15))
			0:       w = word_t'(1) << $urandom_range(0, WORD_W - 1);
			1:       w = ~(word_t'(1) << $urandom_range(0, WORD_W - 1));
			default: ;
		endcase
		return w;
	endfunction

	// Reset, directed states, random states, then drain and verdict.
	initial begin
		state_t s;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		in_word0  <= '0;
		in_word1  <= '0;
		in_word2  <= '0;
		in_word3  <= '0;
		in_word4  <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// All zeros and all ones.
		s = '0;
		offer_state(s);
		s = '1;
		offer_state(s);
		// One word all ones, the rest zero.
		for (int w = 0; w < NUM_WORDS; w++) begin
			s = '0;
			s[w] = '1;
			offer_state(s);
		end
		// Alternating bit patterns in every word.
		s = {NUM_WORDS{64'haaaa_aaaa_aaaa_aaaa}};
		offer_state(s);
		s = {NUM_WORDS{64'h5555_5555_5555_5555}};
		offer_state(s);
		// Top and bottom bit of one word, which the rotations wrap around.
		for (int w = 0; w < NUM_WORDS; w++) begin
			s = '0;
			s[w] = 64'h8000_0000_0000_0001;
			offer_state(s);
		end
		// Distinct byte ramps in every word.
		s[0] = 64'h0001_0203_0405_0607;
		s[1] = 64'h0809_0a0b_0c0d_0e0f;
		s[2] = 64'h1011_1213_1415_1617;
		s[3] = 64'h1819_1a1b_1c1d_1e1f;
		s[4] = 64'h2021_2223_2425_2627;
		offer_state(s);
		n_directed = n_sent;

		// Random states.
		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			for (int w = 0; w < NUM_WORDS; w++)
				s[w] = random_word();
			offer_state(s);
		end
		in_valid <= 1'b0;

		wait (states_in_flight == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("tb_sycon_permutation_320: %0d states sent (%0d directed), %0d results compared",
			n_sent, n_directed, results_seen);
		$display("tb_sycon_permutation_320: output held off once for %0d cycles, %0d mismatches",
			HOLD_CYCLES, mismatches);
		if (mismatches == 0)
			$display("tb_sycon_permutation_320: done, clean");
		else
			$display("tb_sycon_permutation_320: done, errors");
		$finish;
	end

	// Output back-pressure: random stall and run bursts, one long hold-off.
	initial begin
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request && n_sent < CALM_FROM) begin
				hold_request = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (idle_allowed() && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
		end
	end

	// Hard limit on the run time.
	initial begin
		#(LIMIT_CYCLES * 2 * CLK_HALF);
		$display("tb_sycon_permutation_320: done, errors");
		$finish;
	end

endmodule
